// ----- rtl/mbp_pkg.sv -----
package mbp_pkg;

	localparam int DEF_MAX_WORDS = 64;

	localparam int CFG_DATA_W = 4;

	// configuration register indexes
	localparam logic REG_START_SPACE = 1'b0;
	localparam logic REG_CHAR_GAP    = 1'b1;

	localparam logic [3:0] START_SPACE_RST = 4'd7;
	localparam logic [2:0] CHAR_GAP_RST    = 3'd3;
	localparam logic [3:0] SPACE_AFTER_CHAR = 4'd4;

	localparam logic [7:0] SPACE_CHAR  = 8'h20;
	localparam logic [7:0] CASE_MASK   = 8'hDF;
	localparam logic [7:0] LETTER_LO   = 8'h41;
	localparam logic [7:0] LETTER_HI   = 8'h5A;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_t;

	typedef struct packed {
		logic [31:0] packed_word;
		logic [5:0]  word_index;
		logic [11:0] total_bits;
		logic        final_word;
		logic        overflow;
	} out_t;

	// dot-time pattern for each letter, MSB first, ends at the last 1
	function automatic logic [15:0] dot_rom(input logic [4:0] idx);
		logic [15:0] code;
		case (idx)
			5'd0:  code = 16'hB800;
			5'd1:  code = 16'hEA80;
			5'd2:  code = 16'hEBA0;
			5'd3:  code = 16'hEA00;
			5'd4:  code = 16'h8000;
			5'd5:  code = 16'hAE80;
			5'd6:  code = 16'hEE80;
			5'd7:  code = 16'hAA00;
			5'd8:  code = 16'hA000;
			5'd9:  code = 16'hBBB8;
			5'd10: code = 16'hEB80;
			5'd11: code = 16'hBA80;
			5'd12: code = 16'hEE00;
			5'd13: code = 16'hE800;
			5'd14: code = 16'hEEE0;
			5'd15: code = 16'hBBA0;
			5'd16: code = 16'hEEB8;
			5'd17: code = 16'hBA00;
			5'd18: code = 16'hA800;
			5'd19: code = 16'hE000;
			5'd20: code = 16'hAE00;
			5'd21: code = 16'hAB80;
			5'd22: code = 16'hBB80;
			5'd23: code = 16'hEAE0;
			5'd24: code = 16'hEBB8;
			5'd25: code = 16'hEEA0;
			default: code = 16'h0000;
		endcase
		return code;
	endfunction

endpackage

// ----- rtl/morse_bit_packer_top.sv -----
// Morse bit packer. One message byte is taken per request; letters (either case) are
// expanded to dot-time bits, spaces and character gaps to zero bits, and the bits are
// packed MSB first into 32-bit words that leave on the output channel. Bits are moved
// one per clock through a single shift register. After a request is taken, in_stall
// stays high until its N bits are added (N = char gap + space zeros + letter code, at
// most 20), so the next request is taken only once they are all packed. On a
// character marked last, the partial word is aligned by shifting in zeros and flushed,
// followed by an overflow marker word if any word was dropped past MAX_WORDS.
// Bit shifting pauses while a completed word waits for the output register to drain.
// start_space_bits and char_gap_bits must be written only while the block is idle.
module morse_bit_packer_top #(
	parameter int MAX_WORDS = mbp_pkg::DEF_MAX_WORDS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [mbp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  mbp_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output mbp_pkg::out_t                 out_data
);

	localparam int WCW = ($clog2(MAX_WORDS + 1) > 6) ? $clog2(MAX_WORDS + 1) : 6;
	localparam logic [WCW-1:0] WCNT_MAX = WCW'(MAX_WORDS);
	localparam logic [5:0] LAST_IDX = 6'((MAX_WORDS - 1) % 64);

	typedef enum logic [2:0] {
		S_IDLE,
		S_GAP,
		S_SPC,
		S_LET,
		S_FLUSH,
		S_OVF
	} state_t;

	state_t        state_q;
	logic [3:0]    start_q;
	logic [2:0]    gap_q;
	logic [31:0]   partial_q;
	logic [4:0]    bit_pos_q;
	logic [4:0]    al_q;
	logic [WCW-1:0] wcnt_q;
	logic [11:0]   bits_q;
	logic          prev_space_q;
	logic          at_start_q;
	logic          dropped_q;
	logic          last_q;
	logic [2:0]    gap_cnt_q;
	logic [3:0]    spc_cnt_q;
	logic [15:0]   code_q;
	logic          out_valid_q;
	mbp_pkg::out_t out_q;

	logic        in_fire;
	logic        room;
	logic        word_full;
	logic        push_en;
	logic        push_val;
	logic        emit_req;
	logic [31:0] emit_word;
	logic [5:0]  emit_nbits;
	logic        emit_fin;
	logic [12:0] bits_sum;
	logic [11:0] bits_next;
	logic [7:0]  up_char;
	logic        is_space;
	logic        is_letter;
	logic [4:0]  rom_idx;

	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign room      = !out_valid_q;
	assign word_full = (bit_pos_q == 5'd31);

	assign up_char   = in_data.char_code & mbp_pkg::CASE_MASK;
	assign is_space  = (in_data.char_code == mbp_pkg::SPACE_CHAR);
	assign is_letter = (up_char >= mbp_pkg::LETTER_LO) && (up_char <= mbp_pkg::LETTER_HI);
	assign rom_idx   = 5'(up_char - mbp_pkg::LETTER_LO);

	always_comb begin
		push_en    = 1'b0;
		push_val   = 1'b0;
		emit_req   = 1'b0;
		emit_word  = {partial_q[30:0], 1'b0};
		emit_nbits = 6'd32;
		emit_fin   = 1'b0;
		case (state_q)
			S_GAP: begin
				push_en = (gap_cnt_q != 3'd0) && (!word_full || room);
			end
			S_SPC: begin
				push_en = (spc_cnt_q != 4'd0) && (!word_full || room);
			end
			S_LET: begin
				push_en  = (code_q != 16'd0) && (!word_full || room);
				push_val = code_q[15];
			end
			S_FLUSH: begin
				if (partial_q != 32'd0 && al_q == 5'd0 && room) begin
					emit_req   = 1'b1;
					emit_word  = partial_q;
					emit_nbits = {1'b0, bit_pos_q};
					emit_fin   = 1'b1;
				end
			end
			default: ;
		endcase
		if (push_en && word_full) begin
			emit_req  = 1'b1;
			emit_word = {partial_q[30:0], push_val};
		end
	end

	assign bits_sum  = {1'b0, bits_q} + 13'(emit_nbits);
	assign bits_next = bits_sum[12] ? 12'hFFF : bits_sum[11:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			start_q      <= mbp_pkg::START_SPACE_RST;
			gap_q        <= mbp_pkg::CHAR_GAP_RST;
			partial_q    <= 32'd0;
			bit_pos_q    <= 5'd0;
			al_q         <= 5'd0;
			wcnt_q       <= '0;
			bits_q       <= 12'd0;
			prev_space_q <= 1'b0;
			at_start_q   <= 1'b1;
			dropped_q    <= 1'b0;
			last_q       <= 1'b0;
			gap_cnt_q    <= 3'd0;
			spc_cnt_q    <= 4'd0;
			code_q       <= 16'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mbp_pkg::REG_START_SPACE: start_q <= cfg_data[3:0];
					mbp_pkg::REG_CHAR_GAP:    gap_q   <= cfg_data[2:0];
					default: ;
				endcase
			end

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// shared bit pusher
			if (push_en) begin
				if (word_full) begin
					partial_q <= 32'd0;
					bit_pos_q <= 5'd0;
				end else begin
					partial_q <= {partial_q[30:0], push_val};
					bit_pos_q <= bit_pos_q + 5'd1;
				end
			end

			// word accept: emit while buffer has room, else drop
			if (emit_req) begin
				if (wcnt_q < WCNT_MAX) begin
					out_valid_q         <= 1'b1;
					out_q.packed_word   <= emit_word;
					out_q.word_index    <= wcnt_q[5:0];
					out_q.total_bits    <= bits_next;
					out_q.final_word    <= emit_fin;
					out_q.overflow      <= 1'b0;
					bits_q              <= bits_next;
					wcnt_q              <= wcnt_q + WCW'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						last_q    <= in_data.last_char;
						gap_cnt_q <= (!at_start_q && !prev_space_q) ? gap_q : 3'd0;
						if (is_space) begin
							spc_cnt_q <= at_start_q ? start_q :
							             (prev_space_q ? 4'd0 : mbp_pkg::SPACE_AFTER_CHAR);
						end else begin
							spc_cnt_q <= 4'd0;
						end
						code_q       <= is_letter ? mbp_pkg::dot_rom(rom_idx) : 16'd0;
						at_start_q   <= 1'b0;
						prev_space_q <= is_space;
						state_q      <= S_GAP;
					end
				end
				S_GAP: begin
					if (gap_cnt_q == 3'd0) begin
						state_q <= S_SPC;
					end else if (push_en) begin
						gap_cnt_q <= gap_cnt_q - 3'd1;
					end
				end
				S_SPC: begin
					if (spc_cnt_q == 4'd0) begin
						state_q <= S_LET;
					end else if (push_en) begin
						spc_cnt_q <= spc_cnt_q - 4'd1;
					end
				end
				S_LET: begin
					if (code_q == 16'd0) begin
						if (last_q) begin
							al_q    <= bit_pos_q;
							state_q <= S_FLUSH;
						end else begin
							state_q <= S_IDLE;
						end
					end else if (push_en) begin
						code_q <= {code_q[14:0], 1'b0};
					end
				end
				S_FLUSH: begin
					// left-align the partial word by shifting in zeros until the fill wraps
					if (partial_q == 32'd0) begin
						state_q <= S_OVF;
					end else if (al_q != 5'd0) begin
						partial_q <= {partial_q[30:0], 1'b0};
						al_q      <= al_q + 5'd1;
					end else if (room) begin
						state_q <= S_OVF;
					end
				end
				S_OVF: begin
					if (!dropped_q || room) begin
						if (dropped_q) begin
							out_valid_q       <= 1'b1;
							out_q.packed_word <= 32'd0;
							out_q.word_index  <= LAST_IDX;
							out_q.total_bits  <= bits_q;
							out_q.final_word  <= 1'b1;
							out_q.overflow    <= 1'b1;
						end
						partial_q    <= 32'd0;
						bit_pos_q    <= 5'd0;
						wcnt_q       <= '0;
						bits_q       <= 12'd0;
						prev_space_q <= 1'b0;
						at_start_q   <= 1'b1;
						dropped_q    <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_wcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q <= WCNT_MAX)
		else $error("word counter passed buffer capacity");

	a_ovf_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.overflow |-> out_q.final_word && out_q.packed_word == 32'd0)
		else $error("overflow marker malformed");

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		at_start_q && state_q == S_IDLE |-> bit_pos_q == 5'd0 && wcnt_q == '0 && !dropped_q)
		else $error("message state not cleared at message start");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit_req && wcnt_q < WCNT_MAX |-> !out_valid_q)
		else $error("result register loaded while occupied");

endmodule
